// ===== src/a2b_pkg.sv =====
// Package with shared types and constants of the AVCC to Annex B converter.
package a2b_pkg;

    localparam int HEADER_BYTES = 56;
    localparam int ADDR_W = $clog2(HEADER_BYTES);
    localparam int CNT_W = $clog2(HEADER_BYTES + 1);

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_PERR = 2'd1;
    localparam logic [1:0] KIND_LOAD = 2'd2;

    typedef struct packed {
        logic             we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

// ===== src/a2b_ram.sv =====
// Header store: one write port, one registered read port.
module a2b_ram (
    input  logic              clk,
    input  a2b_pkg::mem_req_t req,
    output logic [7:0]        rdata
);

    logic [7:0] mem_reg [a2b_pkg::HEADER_BYTES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_reg[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem_reg[req.raddr];
        end
    end

endmodule

// ===== src/avcc_to_annexb_converter_top.sv =====
// Top level of the AVCC to Annex B converter.
//
// Channel | Signals                                   | Direction
// in      | valid ready mode in_byte last             | sink
// out     | out_valid out_ready kind out_byte run_last ... | source
//
// A packet item is accepted in S_IDLE and then yields its results one per
// cycle while the output is not stalled: the stored header, the start code,
// the NAL byte and an error report, as the item needs. The first header read
// is issued at acceptance, so the read latency of the store adds no wait. A
// load report is set at the accepting edge, and a size byte that opens a stored
// unit goes through S_WSC to write its start code into the store.
// Reset is asynchronous and clears all control state; the store is undefined.
// A stalled output holds the block; the output register holds the result.
module avcc_to_annexb_converter_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    output logic       ready,
    input  logic       mode,
    input  logic [7:0] in_byte,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       sps_present,
    output logic       pps_present,
    output logic       header_error,
    output logic [5:0] header_length
);

    localparam int AW = a2b_pkg::ADDR_W;
    localparam int CW = a2b_pkg::CNT_W;

    // Load phases.
    localparam logic [2:0] LD_SKIP = 3'd0, LD_SPSN = 3'd1, LD_SZHI = 3'd2,
        LD_SZLO = 3'd3, LD_BODY = 3'd4, LD_PPSN = 3'd5, LD_DONE = 3'd6,
        LD_FAIL = 3'd7;
    localparam logic [1:0] PK_PREFIX = 2'd0, PK_FIRST = 2'd1, PK_REST = 2'd2;

    // Sequencer for one item.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_HREAD = 6'b000010,  // header byte being read from the store
        S_SC    = 6'b000100,  // start code bytes
        S_BODY  = 6'b001000,  // the NAL byte itself
        S_ERR   = 6'b010000,  // packet error report
        S_WSC   = 6'b100000   // writing a unit start code into the store
    } seq_t;

    seq_t state_reg, state_next;

    logic [CW-1:0] header_count_reg, header_count_next;
    logic          header_ok_reg, header_ok_next;
    logic [2:0]    load_phase_reg, load_phase_next;
    logic [7:0]    units_reg, units_next;
    logic [15:0]   lbytes_reg, lbytes_next;
    logic [1:0]    seen_reg, seen_next;
    logic [1:0]    pphase_reg, pphase_next;
    logic [1:0]    pidx_reg, pidx_next;
    logic [31:0]   accum_reg, accum_next;
    logic [30:0]   pleft_reg, pleft_next;
    logic          first_reg, first_next;
    logic          drop_reg, drop_next;

    // Per-item work latched at acceptance.
    logic [CW-1:0] hcnt_reg, hcnt_next;     // header bytes left to emit
    logic [AW-1:0] hptr_reg, hptr_next;
    logic [2:0]    sc_reg, sc_next;         // start code bytes left
    logic          body_reg, body_next;     // emit byte after start code
    logic          err_reg, err_next;       // emit error report at end
    logic [7:0]    b_reg, b_next;
    logic [1:0]    wsc_reg, wsc_next;       // start code write index
    logic [CW-1:0] wbase_reg, wbase_next;

    logic          ov_reg, ov_next;
    logic [1:0]    okind_reg, okind_next;
    logic [7:0]    obyte_reg, obyte_next;
    logic          olast_reg, olast_next;
    logic          osps_reg, osps_next, opps_reg, opps_next, oerr_reg, oerr_next;
    logic [5:0]    olen_reg, olen_next;

    a2b_pkg::mem_req_t req;
    logic [7:0] rdata;

    a2b_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

    logic can_out;
    assign can_out = !ov_reg || out_ready;
    assign ready = (state_reg == S_IDLE) && can_out;
    logic acc;
    assign acc = valid && ready;

    assign out_valid = ov_reg;
    assign kind = okind_reg;
    assign out_byte = obyte_reg;
    assign run_last = olast_reg;
    assign sps_present = osps_reg;
    assign pps_present = opps_reg;
    assign header_error = oerr_reg;
    assign header_length = olen_reg;

    logic [16:0] need;
    logic [7:0]  cnt;
    logic [30:0] pl1;

    always_comb
    begin
        state_next = state_reg;
        header_count_next = header_count_reg;
        header_ok_next = header_ok_reg;
        load_phase_next = load_phase_reg;
        units_next = units_reg;
        lbytes_next = lbytes_reg;
        seen_next = seen_reg;
        pphase_next = pphase_reg;
        pidx_next = pidx_reg;
        accum_next = accum_reg;
        pleft_next = pleft_reg;
        first_next = first_reg;
        drop_next = drop_reg;
        hcnt_next = hcnt_reg;
        hptr_next = hptr_reg;
        sc_next = sc_reg;
        body_next = body_reg;
        err_next = err_reg;
        b_next = b_reg;
        wsc_next = wsc_reg;
        wbase_next = wbase_reg;
        ov_next = ov_reg && !out_ready;
        okind_next = okind_reg;
        obyte_next = obyte_reg;
        olast_next = olast_reg;
        osps_next = osps_reg;
        opps_next = opps_reg;
        oerr_next = oerr_reg;
        olen_next = olen_reg;
        req = '0;
        need = '0;
        cnt = '0;
        pl1 = pleft_reg - 31'd1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    hcnt_next = '0;
                    hptr_next = '0;
                    sc_next = '0;
                    body_next = 1'b0;
                    err_next = 1'b0;
                    b_next = in_byte;
                    if (!mode)
                    begin
                        unique case (load_phase_reg)
                            LD_SKIP:
                            begin
                                if (lbytes_reg == 16'd0)
                                begin
                                    header_ok_next = 1'b0;
                                    header_count_next = '0;
                                    seen_next = '0;
                                end
                                if (lbytes_reg >= 16'd4)
                                begin
                                    lbytes_next = '0;
                                    load_phase_next = LD_SPSN;
                                end
                                else
                                begin
                                    lbytes_next = lbytes_reg + 16'd1;
                                end
                            end
                            LD_SPSN, LD_PPSN:
                            begin
                                cnt = (load_phase_reg == LD_SPSN) ?
                                    {3'd0, in_byte[4:0]} : in_byte;
                                if (cnt != 8'd0)
                                begin
                                    seen_next = seen_reg |
                                        ((load_phase_reg == LD_SPSN) ? 2'b01 : 2'b10);
                                    units_next = cnt;
                                    load_phase_next = LD_SZHI;
                                end
                                else
                                begin
                                    load_phase_next = (load_phase_reg == LD_SPSN) ?
                                        LD_PPSN : LD_DONE;
                                end
                            end
                            LD_SZHI:
                            begin
                                lbytes_next = {in_byte, 8'd0};
                                load_phase_next = LD_SZLO;
                            end
                            LD_SZLO:
                            begin
                                lbytes_next = {lbytes_reg[15:8], in_byte};
                                need = 17'(header_count_reg) + 17'd4 +
                                    {1'b0, lbytes_reg[15:8], in_byte};
                                if (need > 17'(a2b_pkg::HEADER_BYTES))
                                begin
                                    header_count_next = '0;
                                    load_phase_next = LD_FAIL;
                                end
                                else
                                begin
                                    // Start code goes to the store in S_WSC.
                                    wbase_next = header_count_reg;
                                    wsc_next = 2'd0;
                                    state_next = S_WSC;
                                    header_count_next = header_count_reg + CW'(4);
                                    if ({lbytes_reg[15:8], in_byte} == 16'd0)
                                    begin
                                        units_next = units_reg - 8'd1;
                                        if (units_reg == 8'd1)
                                            load_phase_next = seen_reg[1] ?
                                                LD_DONE : LD_PPSN;
                                        else
                                            load_phase_next = LD_SZHI;
                                    end
                                    else
                                    begin
                                        load_phase_next = LD_BODY;
                                    end
                                end
                            end
                            LD_BODY:
                            begin
                                if (header_count_reg < CW'(a2b_pkg::HEADER_BYTES))
                                begin
                                    req.we = 1'b1;
                                    req.waddr = AW'(header_count_reg);
                                    req.wdata = in_byte;
                                    header_count_next = header_count_reg + CW'(1);
                                end
                                lbytes_next = lbytes_reg - 16'd1;
                                if (lbytes_reg == 16'd1)
                                begin
                                    units_next = units_reg - 8'd1;
                                    if (units_reg == 8'd1)
                                        load_phase_next = seen_reg[1] ? LD_DONE : LD_PPSN;
                                    else
                                        load_phase_next = LD_SZHI;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        if (last)
                        begin
                            ov_next = 1'b1;
                            okind_next = a2b_pkg::KIND_LOAD;
                            obyte_next = '0;
                            olast_next = 1'b1;
                            // The final phase is known only from the updates above.
                            if (load_phase_next == LD_DONE)
                            begin
                                header_ok_next = 1'b1;
                                osps_next = seen_next[0];
                                opps_next = seen_next[1];
                                oerr_next = 1'b0;
                                olen_next = 6'(header_count_next);
                            end
                            else
                            begin
                                header_ok_next = 1'b0;
                                header_count_next = '0;
                                osps_next = 1'b0;
                                opps_next = 1'b0;
                                oerr_next = 1'b1;
                                olen_next = '0;
                            end
                            load_phase_next = LD_SKIP;
                            lbytes_next = '0;
                            units_next = '0;
                        end
                    end
                    else if (drop_reg)
                    begin
                        if (last)
                        begin
                            pphase_next = PK_PREFIX;
                            pidx_next = '0;
                            accum_next = '0;
                            pleft_next = '0;
                            first_next = 1'b1;
                            drop_next = 1'b0;
                        end
                    end
                    else
                    begin
                        case (pphase_reg)
                            PK_PREFIX:
                            begin
                                accum_next = {accum_reg[23:0], in_byte};
                                pidx_next = pidx_reg + 2'd1;
                                if (pidx_reg == 2'd3)
                                begin
                                    if (accum_reg[23])
                                    begin
                                        err_next = 1'b1;
                                        pidx_next = '0;
                                        accum_next = '0;
                                        pleft_next = '0;
                                        first_next = 1'b1;
                                        drop_next = !last;
                                    end
                                    else
                                    begin
                                        pleft_next = {accum_reg[22:0], in_byte};
                                        accum_next = '0;
                                        if ({accum_reg[22:0], in_byte} == 31'd0)
                                            sc_next = first_reg ? 3'd4 : 3'd3;
                                        else
                                            pphase_next = PK_FIRST;
                                    end
                                end
                            end
                            PK_FIRST:
                            begin
                                if (!(last && pleft_reg > 31'd1))
                                begin
                                    if (in_byte[4:0] == 5'd5 && header_ok_reg)
                                        hcnt_next = header_count_reg;
                                    sc_next = first_reg ? 3'd4 : 3'd3;
                                    body_next = 1'b1;
                                    pleft_next = pl1;
                                    pphase_next = (pl1 != 31'd0) ? PK_REST : PK_PREFIX;
                                end
                            end
                            default:
                            begin
                                body_next = 1'b1;
                                pleft_next = pl1;
                                if (pl1 == 31'd0)
                                    pphase_next = PK_PREFIX;
                            end
                        endcase
                        if (last && !(pidx_reg == 2'd3 && accum_reg[23]))
                        begin
                            if (pphase_next != PK_PREFIX || pidx_next != 2'd0)
                                err_next = 1'b1;
                            pphase_next = PK_PREFIX;
                            pidx_next = '0;
                            accum_next = '0;
                            pleft_next = '0;
                            first_next = 1'b1;
                            drop_next = 1'b0;
                        end
                        else if (sc_next != 3'd0)
                        begin
                            first_next = 1'b0;
                        end
                        if (last && sc_next != 3'd0)
                            first_next = 1'b1;
                        if (hcnt_next != '0)
                        begin
                            req.re = 1'b1;
                            req.raddr = '0;
                            hptr_next = AW'(1);
                            state_next = S_HREAD;
                        end
                        else if (sc_next != 3'd0)
                            state_next = S_SC;
                        else if (body_next)
                            state_next = S_BODY;
                        else if (err_next)
                            state_next = S_ERR;
                    end
                end
            end
            S_WSC:
            begin
                req.we = 1'b1;
                req.waddr = AW'(wbase_reg + CW'(wsc_reg));
                req.wdata = (wsc_reg == 2'd3) ? 8'd1 : 8'd0;
                wsc_next = wsc_reg + 2'd1;
                if (wsc_reg == 2'd3)
                    state_next = S_IDLE;
            end
            default:
            begin
                if (can_out)
                begin
                    ov_next = 1'b1;
                    okind_next = a2b_pkg::KIND_BYTE;
                    olast_next = 1'b0;
                    osps_next = 1'b0;
                    opps_next = 1'b0;
                    oerr_next = 1'b0;
                    olen_next = '0;
                    unique case (state_reg)
                        S_HREAD:
                        begin
                            obyte_next = rdata;
                            hcnt_next = hcnt_reg - CW'(1);
                            if (hcnt_reg != CW'(1))
                            begin
                                req.re = 1'b1;
                                req.raddr = hptr_reg;
                                hptr_next = hptr_reg + AW'(1);
                            end
                            else
                                state_next = S_SC;
                        end
                        S_SC:
                        begin
                            obyte_next = (sc_reg == 3'd1) ? 8'd1 : 8'd0;
                            sc_next = sc_reg - 3'd1;
                            if (sc_reg == 3'd1)
                            begin
                                if (body_reg)
                                    state_next = S_BODY;
                                else if (err_reg)
                                    state_next = S_ERR;
                                else
                                begin
                                    olast_next = 1'b1;
                                    state_next = S_IDLE;
                                end
                            end
                        end
                        S_BODY:
                        begin
                            obyte_next = b_reg;
                            if (err_reg)
                                state_next = S_ERR;
                            else
                            begin
                                olast_next = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        default:
                        begin
                            okind_next = a2b_pkg::KIND_PERR;
                            obyte_next = '0;
                            olast_next = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            header_count_reg <= '0;
            header_ok_reg <= 1'b0;
            load_phase_reg <= LD_SKIP;
            units_reg <= '0;
            lbytes_reg <= '0;
            seen_reg <= '0;
            pphase_reg <= PK_PREFIX;
            pidx_reg <= '0;
            accum_reg <= '0;
            pleft_reg <= '0;
            first_reg <= 1'b1;
            drop_reg <= 1'b0;
            hcnt_reg <= '0;
            sc_reg <= '0;
            body_reg <= 1'b0;
            err_reg <= 1'b0;
            wsc_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            header_count_reg <= header_count_next;
            header_ok_reg <= header_ok_next;
            load_phase_reg <= load_phase_next;
            units_reg <= units_next;
            lbytes_reg <= lbytes_next;
            seen_reg <= seen_next;
            pphase_reg <= pphase_next;
            pidx_reg <= pidx_next;
            accum_reg <= accum_next;
            pleft_reg <= pleft_next;
            first_reg <= first_next;
            drop_reg <= drop_next;
            hcnt_reg <= hcnt_next;
            sc_reg <= sc_next;
            body_reg <= body_next;
            err_reg <= err_next;
            wsc_reg <= wsc_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hptr_reg <= hptr_next;
        b_reg <= b_next;
        wbase_reg <= wbase_next;
        okind_reg <= okind_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        osps_reg <= osps_next;
        opps_reg <= opps_next;
        oerr_reg <= oerr_next;
        olen_reg <= olen_next;
    end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the AVCC to Annex B converter.
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       run_last;
        logic       sps;
        logic       pps;
        logic       err;
        logic [5:0] hlen;
    } stream_result_t;

    typedef enum logic [2:0] {
        LP_SKIP, LP_SPS_COUNT, LP_SIZE_HI, LP_SIZE_LO, LP_BODY, LP_PPS_COUNT, LP_DONE, LP_FAIL
    } load_phase_t;

    typedef enum logic [1:0] {PP_PREFIX, PP_FIRST, PP_REST} pkt_phase_t;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_PACKET = 1'b1;
    localparam logic [4:0] NAL_IDR = 5'd5;

    int error_count = 0;

    // Reports one mismatch on a line of its own and counts it.
    task automatic report(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        error_count++;
    endtask

    // Holds the converter's state as seen from outside and the queue of
    // output items that the accepted input items are due to produce.
    class annexb_scoreboard;
        logic [7:0]  hdr_mem [a2b_pkg::HEADER_BYTES];
        int unsigned hdr_count;
        bit          hdr_ok;
        load_phase_t lphase;
        int unsigned units_left;
        int unsigned bytes_left;
        bit [1:0]    seen;
        pkt_phase_t  pphase;
        int unsigned pfx_idx;
        bit [31:0]   len_acc;
        int unsigned pay_left;
        bit          first_nal;
        bit          drop;
        stream_result_t pending[$];

        function new();
            hdr_count = 0; hdr_ok = 0; lphase = LP_SKIP; units_left = 0;
            bytes_left = 0; seen = 0;
            packet_clear();
        endfunction

        function void packet_clear();
            pphase = PP_PREFIX; pfx_idx = 0; len_acc = 0; pay_left = 0;
            first_nal = 1; drop = 0;
        endfunction

        function void push(stream_result_t r);
            pending.push_back(r);
        endfunction

        function void emit_byte(input logic [1:0] k, input logic [7:0] b);
            stream_result_t r;
            r = '{k, b, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0};
            push(r);
        endfunction

        function void emit_start_code();
            if (first_nal)
                emit_byte(a2b_pkg::KIND_BYTE, 8'h00);
            emit_byte(a2b_pkg::KIND_BYTE, 8'h00);
            emit_byte(a2b_pkg::KIND_BYTE, 8'h00);
            emit_byte(a2b_pkg::KIND_BYTE, 8'h01);
            first_nal = 0;
        endfunction

        function void unit_done();
            units_left = (units_left - 1) & 8'hff;
            if (units_left == 0)
                lphase = seen[1] ? LP_DONE : LP_PPS_COUNT;
            else
                lphase = LP_SIZE_HI;
        endfunction

        function void record_byte(input logic [7:0] b, input logic lst);
            stream_result_t r;
            case (lphase)
                LP_SKIP: begin
                    if (bytes_left == 0)
                    begin
                        hdr_ok = 0; hdr_count = 0; seen = 0;
                    end
                    bytes_left++;
                    if (bytes_left >= 5)
                    begin
                        bytes_left = 0; lphase = LP_SPS_COUNT;
                    end
                end
                LP_SPS_COUNT, LP_PPS_COUNT: begin
                    int unsigned cnt;
                    cnt = (lphase == LP_SPS_COUNT) ? int'(b[4:0]) : int'(b);
                    if (cnt != 0)
                    begin
                        seen |= (lphase == LP_SPS_COUNT) ? 2'b01 : 2'b10;
                        units_left = cnt;
                        lphase = LP_SIZE_HI;
                    end
                    else
                        lphase = (lphase == LP_SPS_COUNT) ? LP_PPS_COUNT : LP_DONE;
                end
                LP_SIZE_HI: begin
                    bytes_left = int'(b) << 8;
                    lphase = LP_SIZE_LO;
                end
                LP_SIZE_LO: begin
                    bytes_left |= b;
                    if (hdr_count + 4 + bytes_left > a2b_pkg::HEADER_BYTES)
                    begin
                        hdr_count = 0; lphase = LP_FAIL;
                    end
                    else
                    begin
                        hdr_mem[hdr_count] = 0; hdr_mem[hdr_count+1] = 0;
                        hdr_mem[hdr_count+2] = 0; hdr_mem[hdr_count+3] = 1;
                        hdr_count += 4;
                        if (bytes_left == 0) unit_done();
                        else lphase = LP_BODY;
                    end
                end
                LP_BODY: begin
                    if (hdr_count < a2b_pkg::HEADER_BYTES)
                    begin
                        hdr_mem[hdr_count] = b; hdr_count++;
                    end
                    bytes_left--;
                    if (bytes_left == 0) unit_done();
                end
                default: ;
            endcase
            if (lst)
            begin
                if (lphase == LP_DONE)
                begin
                    hdr_ok = 1;
                    r = '{a2b_pkg::KIND_LOAD, 8'h00, 1'b0, seen[0], seen[1], 1'b0,
                          6'(hdr_count)};
                end
                else
                begin
                    hdr_ok = 0; hdr_count = 0;
                    r = '{a2b_pkg::KIND_LOAD, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 6'd0};
                end
                push(r);
                lphase = LP_SKIP; bytes_left = 0; units_left = 0;
            end
        endfunction

        function void packet_byte(input logic [7:0] b, input logic lst);
            if (drop)
            begin
                if (lst) packet_clear();
                return;
            end
            case (pphase)
                PP_PREFIX: begin
                    len_acc = (len_acc << 8) | b;
                    pfx_idx = (pfx_idx + 1) & 3;
                    if (pfx_idx == 0)
                    begin
                        if (len_acc[31])
                        begin
                            emit_byte(a2b_pkg::KIND_PERR, 8'h00);
                            packet_clear();
                            if (!lst) drop = 1;
                            return;
                        end
                        pay_left = len_acc;
                        len_acc = 0;
                        if (pay_left == 0) emit_start_code();
                        else pphase = PP_FIRST;
                    end
                end
                PP_FIRST: begin
                    if (!(lst && pay_left > 1))
                    begin
                        if (b[4:0] == NAL_IDR && hdr_ok)
                            for (int i = 0; i < hdr_count && i < a2b_pkg::HEADER_BYTES; i++)
                                emit_byte(a2b_pkg::KIND_BYTE, hdr_mem[i]);
                        emit_start_code();
                        emit_byte(a2b_pkg::KIND_BYTE, b);
                        pay_left--;
                        pphase = (pay_left != 0) ? PP_REST : PP_PREFIX;
                    end
                end
                default: begin
                    emit_byte(a2b_pkg::KIND_BYTE, b);
                    pay_left--;
                    if (pay_left == 0) pphase = PP_PREFIX;
                end
            endcase
            if (lst)
            begin
                if (pphase != PP_PREFIX || pfx_idx != 0)
                    emit_byte(a2b_pkg::KIND_PERR, 8'h00);
                packet_clear();
            end
        endfunction

        // Notes an accepted input item and queues the items it produces.
        function void note_input(input logic m, input logic [7:0] b, input logic lst);
            int before_n;
            before_n = pending.size();
            if (m == MODE_PACKET) packet_byte(b, lst);
            else record_byte(b, lst);
            if (pending.size() > before_n)
                pending[pending.size()-1].run_last = 1'b1;
        endfunction

        // Compares one accepted output item with the oldest expected one.
        task check_result(input stream_result_t got);
            stream_result_t exp_r;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected output item kind=%0d byte=%02h",
                                 got.kind, got.out_byte));
                return;
            end
            exp_r = pending.pop_front();
            if (got.kind !== exp_r.kind)
                report($sformatf("kind got %0d want %0d", got.kind, exp_r.kind));
            if (got.out_byte !== exp_r.out_byte)
                report($sformatf("out_byte got %02h want %02h", got.out_byte, exp_r.out_byte));
            if (got.run_last !== exp_r.run_last)
                report($sformatf("run_last got %0b want %0b", got.run_last, exp_r.run_last));
            if (got.sps !== exp_r.sps)
                report($sformatf("sps_present got %0b want %0b", got.sps, exp_r.sps));
            if (got.pps !== exp_r.pps)
                report($sformatf("pps_present got %0b want %0b", got.pps, exp_r.pps));
            if (got.err !== exp_r.err)
                report($sformatf("header_error got %0b want %0b", got.err, exp_r.err));
            if (got.hlen !== exp_r.hlen)
                report($sformatf("header_length got %0d want %0d", got.hlen, exp_r.hlen));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       valid = 1'b0;
    logic       ready;
    logic       mode = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       run_last;
    logic       sps_present;
    logic       pps_present;
    logic       header_error;
    logic [5:0] header_length;

    annexb_scoreboard sb;
    int unsigned gap_left = 0;     // idle cycles still due before the next item
    int unsigned burst_left = 0;   // items still due in the current burst
    int unsigned stall_mode = 0;   // receiver pattern selector
    int unsigned cycle_n = 0;
    int unsigned sent_items = 0;   // input items accepted so far

    avcc_to_annexb_converter_top dut (.*);

    always #4 clk = ~clk;

    // The receiver cycles through phases: always ready, random stalls, and a
    // periodic stall pattern, so back-pressure lands on every phase of work.
    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if (cycle_n % 300 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= (cycle_n % 7 < 4);
        endcase
    end

    // Output monitor: every accepted output item is checked in order.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{kind, out_byte, run_last, sps_present, pps_present,
                              header_error, header_length});
    end

    // Sends one input item. Between bursts the sender waits a random gap,
    // then holds valid until the item is accepted. The prediction is updated
    // at the accepting edge, before any result of the item can appear.
    task automatic send_item(input logic m, input logic [7:0] b, input logic lst);
        if (burst_left == 0)
        begin
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap_left != 0)
            begin
                valid <= 1'b0;
                repeat (gap_left) @(posedge clk);
            end
        end
        burst_left--;
        valid <= 1'b1;
        mode <= m;
        in_byte <= b;
        last <= lst;
        do
            @(posedge clk);
        while (!ready);
        sb.note_input(m, b, lst);
        sent_items++;
    endtask

    // Sends a full configuration record: preamble, SPS list and PPS list.
    // sps_n and pps_n units of the given body sizes; truncate cuts it short.
    task automatic send_record(input int sps_n, input int pps_n, input int body_max,
                               input bit truncate);
        int total;
        int sizes[$];
        logic [7:0] bytes[$];
        for (int i = 0; i < 5; i++) bytes.push_back(8'($urandom_range(0, 255)));
        bytes.push_back({3'($urandom), 5'(sps_n)});
        for (int i = 0; i < sps_n + pps_n; i++)
        begin
            int sz;
            if (i == sps_n) bytes.push_back(8'(pps_n));
            sz = $urandom_range(0, body_max);
            bytes.push_back(8'(sz >> 8));
            bytes.push_back(8'(sz));
            for (int j = 0; j < sz; j++) bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (sps_n + pps_n == 0 || pps_n == 0)
            bytes.push_back(8'(pps_n));
        if ($urandom_range(0, 4) == 0)
            bytes.push_back(8'($urandom_range(0, 255)));   // trailing byte, ignored
        total = bytes.size();
        if (truncate) total = $urandom_range(1, total - 1);
        for (int i = 0; i < total; i++)
            send_item(MODE_RECORD, bytes[i], i == total - 1);
    endtask

    // Sends one packet of nal_n NAL units with random sizes up to len_max.
    task automatic send_packet(input int nal_n, input int len_max, input bit idr_first,
                               input bit truncate);
        logic [7:0] bytes[$];
        int total;
        for (int n = 0; n < nal_n; n++)
        begin
            int len;
            len = $urandom_range(0, len_max);
            bytes.push_back(8'h00); bytes.push_back(8'h00);
            bytes.push_back(8'(len >> 8)); bytes.push_back(8'(len));
            for (int j = 0; j < len; j++)
            begin
                if (j == 0 && idr_first && n == 0)
                    bytes.push_back({3'($urandom), NAL_IDR});
                else
                    bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        total = bytes.size();
        if (total == 0) return;
        if (truncate) total = $urandom_range(1, total);
        for (int i = 0; i < total; i++)
            send_item(MODE_PACKET, bytes[i], i == total - 1);
    endtask

    // Sends raw noise bytes in either mode.
    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      $urandom_range(0, 5) == 0);
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: an IDR packet before any load inserts nothing, then
        // a good record, oversize and truncated records, and packet special
        // cases: oversize prefix, truncation inside a prefix and a NAL whose
        // first payload byte arrives with last too early.
        send_item(MODE_PACKET, 8'h00, 1'b0);
        send_item(MODE_PACKET, 8'h00, 1'b0);
        send_item(MODE_PACKET, 8'h00, 1'b0);
        send_item(MODE_PACKET, 8'h01, 1'b0);
        send_item(MODE_PACKET, 8'h65, 1'b1);
        send_record(1, 1, 4, 1'b0);
        send_packet(2, 3, 1'b1, 1'b0);
        send_item(MODE_PACKET, 8'hff, 1'b0);
        send_item(MODE_PACKET, 8'hff, 1'b0);
        send_item(MODE_PACKET, 8'hff, 1'b0);
        send_item(MODE_PACKET, 8'hff, 1'b0);
        send_item(MODE_PACKET, 8'h00, 1'b1);
        send_item(MODE_PACKET, 8'h00, 1'b0);
        send_item(MODE_PACKET, 8'h00, 1'b1);
        send_item(MODE_PACKET, 8'h00, 1'b0);
        send_item(MODE_PACKET, 8'h00, 1'b0);
        send_item(MODE_PACKET, 8'h00, 1'b0);
        send_item(MODE_PACKET, 8'h05, 1'b0);
        send_item(MODE_PACKET, 8'h65, 1'b1);
        // Too large: one SPS whose size alone overflows the store.
        for (int i = 0; i < 5; i++) send_item(MODE_RECORD, 8'hff, 1'b0);
        send_item(MODE_RECORD, 8'hE1, 1'b0);
        send_item(MODE_RECORD, 8'h00, 1'b0);
        send_item(MODE_RECORD, 8'd60, 1'b0);
        send_item(MODE_RECORD, 8'h00, 1'b1);
        send_record(1, 1, 4, 1'b1);             // truncated
        send_record(0, 0, 0, 1'b0);             // empty lists
        // Fill the store to its full size: one SPS of 52 body bytes.
        for (int i = 0; i < 5; i++) send_item(MODE_RECORD, 8'hff, 1'b0);
        send_item(MODE_RECORD, 8'hE1, 1'b0);
        send_item(MODE_RECORD, 8'h00, 1'b0);
        send_item(MODE_RECORD, 8'd52, 1'b0);
        for (int i = 0; i < 52; i++) send_item(MODE_RECORD, 8'(i * 5), 1'b0);
        send_item(MODE_RECORD, 8'h00, 1'b1);
        send_packet(1, 2, 1'b1, 1'b0);

        // Random part: mostly well-formed records and packets with random
        // content, some truncated, and some noise.
        while (sent_items < 160)
        begin
            int pick;
            pick = $urandom_range(0, 9);
            if (pick < 2)
                send_record($urandom_range(0, 3), $urandom_range(0, 2),
                            $urandom_range(0, 1) ? 6 : 20, $urandom_range(0, 4) == 0);
            else if (pick < 9)
                send_packet($urandom_range(1, 3), 8, $urandom_range(0, 1),
                            $urandom_range(0, 5) == 0);
            else
                send_noise($urandom_range(1, 8));
        end
        valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.pending.size() == 0 && error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
